// ===== hw/rtl/cdfp_pkg.sv =====
`default_nettype none
package cdfp_pkg;

    localparam int MAX_FIELD_CHARS = 15;
    localparam int MAX_PIXELS      = 2097152;
    localparam int FRAC_BITS       = 16;

    localparam int CHR_W  = $clog2(MAX_FIELD_CHARS + 1);
    localparam int CNT_W  = $clog2(2 * MAX_PIXELS + 1);
    localparam int LIM_W  = (CNT_W > 22) ? CNT_W : 22;
    localparam int ACC_W  = 50;
    localparam int EXP_W  = 7;
    localparam int K_W    = 9;
    localparam int GAIN_W = 9;
    localparam int DIV_W  = 16;
    localparam int NUM_W  = 128;
    localparam int VAL_W  = 48;
    localparam int Q_W    = VAL_W + 1;
    localparam int IDX_W  = 21;
    localparam int ST_W   = 3;

    localparam int EXPO_GAIN = 260;
    localparam int EXP_CAP   = 127;
    localparam int K_MIN     = -30;
    localparam int NUM_TOP   = 120;

    localparam logic [3:0] CFG_PIXEL_LIMIT = 4'd0;
    localparam logic [3:0] CFG_EXP_ENABLE  = 4'd1;
    localparam logic [3:0] CFG_EXP_TIME    = 4'd2;
    localparam logic [3:0] CFG_RGBG        = 4'd3;

    localparam logic [ST_W-1:0] ST_VALUE     = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_MALFORMED = 3'd2;
    localparam logic [ST_W-1:0] ST_TOO_MANY  = 3'd3;
    localparam logic [ST_W-1:0] ST_TOO_LONG  = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_VALUE  = 3'd5;

    typedef struct packed {
        logic                   start;
        logic [ACC_W-1:0]       mant;
        logic signed [K_W-1:0]  k;
        logic [GAIN_W-1:0]      gain;
        logic [DIV_W-1:0]       div;
    } t_scale_req;

    typedef struct packed {
        logic             done;
        logic             over;
        logic [VAL_W-1:0] mag;
    } t_scale_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/cdfp_scaler.sv =====
`default_nettype none
// round(mant * gain * 2^FRAC_BITS * 10^k / div), one x10 or one
// compare-subtract per cycle. over is set when the result reaches 2^48.
module cdfp_scaler (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cdfp_pkg::t_scale_req  i_req,
    output cdfp_pkg::t_scale_rsp       o_rsp
);
    localparam int PROD_W = cdfp_pkg::ACC_W + cdfp_pkg::GAIN_W;
    localparam int DSR_W  = cdfp_pkg::NUM_W + cdfp_pkg::Q_W;
    localparam int CNT_W  = $clog2(cdfp_pkg::Q_W);

    typedef enum logic [1:0] {S_IDLE, S_SCALE, S_DIV, S_DONE} t_state;

    t_state                          r_state, n_state;
    logic [cdfp_pkg::NUM_W-1:0]      r_num, n_num;
    logic [cdfp_pkg::NUM_W-1:0]      r_den, n_den;
    logic signed [cdfp_pkg::K_W-1:0] r_k, n_k;
    logic [cdfp_pkg::NUM_W-1:0]      r_rem, n_rem;
    logic [DSR_W-1:0]                r_dsr, n_dsr;
    logic [cdfp_pkg::Q_W-1:0]        r_q, n_q;
    logic [CNT_W-1:0]                r_cnt, n_cnt;

    logic [PROD_W-1:0]               prod;
    logic [cdfp_pkg::NUM_W-1:0]      x10_src, x10;
    logic                            ge;

    always_comb begin
        prod    = PROD_W'(i_req.mant) * PROD_W'(i_req.gain);
        x10_src = (r_k > 0) ? r_num : r_den;
        x10     = (x10_src << 3) + (x10_src << 1);
        ge      = {{cdfp_pkg::Q_W{1'b0}}, r_rem} >= r_dsr;

        n_state = r_state;
        n_num   = r_num;
        n_den   = r_den;
        n_k     = r_k;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_q     = r_q;
        n_cnt   = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    if (i_req.mant == '0 || i_req.k <= cdfp_pkg::K_MIN) begin
                        n_q     = '0;
                        n_state = S_DONE;
                    end else begin
                        n_num   = {{(cdfp_pkg::NUM_W-PROD_W){1'b0}}, prod}
                                  << cdfp_pkg::FRAC_BITS;
                        n_den   = {{(cdfp_pkg::NUM_W-cdfp_pkg::DIV_W){1'b0}}, i_req.div};
                        n_k     = i_req.k;
                        n_state = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                if (r_k > 0) begin
                    if (|r_num[cdfp_pkg::NUM_W-1:cdfp_pkg::NUM_TOP]) begin
                        n_q     = {1'b1, {cdfp_pkg::VAL_W{1'b0}}};
                        n_state = S_DONE;
                    end else begin
                        n_num = x10;
                        n_k   = r_k - cdfp_pkg::K_W'(1);
                    end
                end else if (r_k < 0) begin
                    n_den = x10;
                    n_k   = r_k + cdfp_pkg::K_W'(1);
                end else begin
                    // (2*num + den) / (2*den) gives round half up
                    n_rem   = (r_num << 1) + r_den;
                    n_dsr   = {{(cdfp_pkg::Q_W-1){1'b0}}, r_den, 1'b0} << cdfp_pkg::VAL_W;
                    n_q     = '0;
                    n_cnt   = CNT_W'(cdfp_pkg::Q_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_q   = {r_q[cdfp_pkg::Q_W-2:0], ge};
                if (ge) n_rem = r_rem - r_dsr[cdfp_pkg::NUM_W-1:0];
                n_dsr = r_dsr >> 1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_k   <= n_k;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.over = r_q[cdfp_pkg::Q_W-1];
    assign o_rsp.mag  = r_q[cdfp_pkg::VAL_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/csv_decimal_field_parser_top.sv =====
`default_nettype none
// CSV decimal field parser.
// Input channel: one text byte per word (i_text_byte, i_end_of_stream),
// taken when i_in_valid is high and o_in_stall is low. Output channel: one
// result word (value Q31.16, pixel index, status, last) offered on
// o_out_valid, held while i_out_stall is high. Config writes go through
// i_cfg_valid/o_cfg_ready with a register index; ready is always high.
// A byte that ends a field is scaled: with k the exponent minus the fraction
// digits, the shared x10 unit runs up to |k| steps, then the compare-subtract
// unit produces 49 quotient bits, one per cycle.
// A finished result sits in the output register; the next byte is accepted
// meanwhile, and the block waits only if a new result is ready while the
// old one is still stalled.
// Reset (synchronous, active low) clears the field, the field count, the
// halt flag and loads the register defaults. After an error result the
// parser halts: bytes are taken and dropped until reset.
module csv_decimal_field_parser_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_text_byte,
    input  wire logic                           i_end_of_stream,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [cdfp_pkg::VAL_W-1:0]   o_value,
    output logic [cdfp_pkg::IDX_W-1:0]          o_pixel_index,
    output logic [cdfp_pkg::ST_W-1:0]           o_status,
    output logic                                o_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [3:0]                     i_cfg_index,
    input  wire logic [21:0]                    i_cfg_data
);
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int FL_SCI  = 0;
    localparam int FL_DOT  = 1;
    localparam int FL_NEG  = 2;
    localparam int FL_ENEG = 3;
    localparam int FL_EPOS = 4;
    localparam int FL_EDOT = 5;

    localparam int CW = cdfp_pkg::CHR_W;
    localparam int NW = cdfp_pkg::CNT_W;
    localparam int VW = cdfp_pkg::VAL_W;

    typedef enum logic [1:0] {S_IDLE, S_END, S_WAIT, S_EMIT} t_state;

    t_state                            r_state, n_state;
    logic [cdfp_pkg::ACC_W-1:0]        r_macc, n_macc;
    logic [CW-1:0]                     r_mchars, n_mchars;
    logic [CW-1:0]                     r_frac, n_frac;
    logic [cdfp_pkg::EXP_W-1:0]        r_eacc, n_eacc;
    logic [CW-1:0]                     r_echars, n_echars;
    logic [5:0]                        r_flags, n_flags;
    logic [NW-1:0]                     r_count, n_count;
    logic                              r_halted, n_halted;
    logic [21:0]                       r_cfg_limit, n_cfg_limit;
    logic                              r_cfg_exp_en, n_cfg_exp_en;
    logic [15:0]                       r_cfg_exp_time, n_cfg_exp_time;
    logic                              r_cfg_rgbg, n_cfg_rgbg;
    logic                              r_eos, n_eos;
    logic                              r_neg, n_neg;
    logic [VW-1:0]                     r_p_value, n_p_value;
    logic [cdfp_pkg::IDX_W-1:0]        r_p_idx, n_p_idx;
    logic [cdfp_pkg::ST_W-1:0]         r_p_status, n_p_status;
    logic                              r_p_last, n_p_last;
    logic                              r_out_valid, n_out_valid;
    logic [VW-1:0]                     r_o_value, n_o_value;
    logic [cdfp_pkg::IDX_W-1:0]        r_o_idx, n_o_idx;
    logic [cdfp_pkg::ST_W-1:0]         r_o_status, n_o_status;
    logic                              r_o_last, n_o_last;
    cdfp_pkg::t_scale_req              r_req, n_req;
    cdfp_pkg::t_scale_rsp              scale_rsp;

    logic                              is_digit, sci, fail, delim, open_field;
    logic [cdfp_pkg::ST_W-1:0]         fcode;
    logic [cdfp_pkg::ACC_W+3:0]        macc_w;
    logic [10:0]                       eacc_w;
    logic signed [cdfp_pkg::K_W-1:0]   k_exp, k_val;
    logic [NW-1:0]                     idx;
    logic [cdfp_pkg::LIM_W-1:0]        limit;
    logic [VW:0]                       mag, sat, neg_sat;

    cdfp_scaler u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (scale_rsp)
    );

    always_comb begin
        is_digit = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
        sci      = r_flags[FL_SCI];
        macc_w   = {r_macc, 3'b000} + {2'b00, r_macc, 1'b0}
                 + {{cdfp_pkg::ACC_W{1'b0}}, i_text_byte[3:0]};
        eacc_w   = {1'b0, r_eacc, 3'b000} + {3'b000, r_eacc, 1'b0}
                 + {7'd0, i_text_byte[3:0]};
        k_exp    = r_flags[FL_SCI]
                 ? (r_flags[FL_ENEG] ? -$signed({2'b00, r_eacc}) : $signed({2'b00, r_eacc}))
                 : '0;
        k_val    = k_exp - $signed({{(cdfp_pkg::K_W-CW){1'b0}}, r_frac});
        idx      = r_cfg_rgbg ? (r_count >> 1) : r_count;
        limit    = ({{(cdfp_pkg::LIM_W-22){1'b0}}, r_cfg_limit}
                    < cdfp_pkg::LIM_W'(cdfp_pkg::MAX_PIXELS))
                 ? {{(cdfp_pkg::LIM_W-22){1'b0}}, r_cfg_limit}
                 : cdfp_pkg::LIM_W'(cdfp_pkg::MAX_PIXELS);
        mag      = {scale_rsp.over, scale_rsp.mag};
        if (r_neg) begin
            sat = (mag > {2'b01, {(VW-1){1'b0}}}) ? {2'b01, {(VW-1){1'b0}}} : mag;
        end else begin
            sat = (mag > {2'b00, {(VW-1){1'b1}}}) ? {2'b00, {(VW-1){1'b1}}} : mag;
        end
        neg_sat  = ~sat + (VW+1)'(1);

        fail       = 1'b0;
        fcode      = cdfp_pkg::ST_MALFORMED;
        delim      = 1'b0;
        open_field = 1'b0;

        n_state        = r_state;
        n_macc         = r_macc;
        n_mchars       = r_mchars;
        n_frac         = r_frac;
        n_eacc         = r_eacc;
        n_echars       = r_echars;
        n_flags        = r_flags;
        n_count        = r_count;
        n_halted       = r_halted;
        n_cfg_limit    = r_cfg_limit;
        n_cfg_exp_en   = r_cfg_exp_en;
        n_cfg_exp_time = r_cfg_exp_time;
        n_cfg_rgbg     = r_cfg_rgbg;
        n_eos          = r_eos;
        n_neg          = r_neg;
        n_p_value      = r_p_value;
        n_p_idx        = r_p_idx;
        n_p_status     = r_p_status;
        n_p_last       = r_p_last;
        n_out_valid    = r_out_valid;
        n_o_value      = r_o_value;
        n_o_idx        = r_o_idx;
        n_o_status     = r_o_status;
        n_o_last       = r_o_last;
        n_req          = r_req;
        n_req.start    = 1'b0;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                cdfp_pkg::CFG_PIXEL_LIMIT: n_cfg_limit    = i_cfg_data;
                cdfp_pkg::CFG_EXP_ENABLE:  n_cfg_exp_en   = i_cfg_data[0];
                cdfp_pkg::CFG_EXP_TIME:    n_cfg_exp_time = i_cfg_data[15:0];
                cdfp_pkg::CFG_RGBG:        n_cfg_rgbg     = i_cfg_data[0];
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_halted) begin
                    case (i_text_byte)
                        CH_COMMA, CH_LF: delim = 1'b1;
                        CH_E: n_flags[FL_SCI] = 1'b1;
                        CH_DOT: begin
                            if (r_flags[FL_DOT]) begin
                                fail = 1'b1;
                            end else if (sci) begin
                                if (r_echars >= CW'(cdfp_pkg::MAX_FIELD_CHARS)) begin
                                    fail  = 1'b1;
                                    fcode = cdfp_pkg::ST_TOO_LONG;
                                end
                                n_echars         = r_echars + CW'(1);
                                n_flags[FL_DOT]  = 1'b1;
                                n_flags[FL_EDOT] = 1'b1;
                            end else begin
                                if (r_mchars >= CW'(cdfp_pkg::MAX_FIELD_CHARS)) begin
                                    fail  = 1'b1;
                                    fcode = cdfp_pkg::ST_TOO_LONG;
                                end
                                n_mchars        = r_mchars + CW'(1);
                                n_flags[FL_DOT] = 1'b1;
                            end
                        end
                        CH_MINUS: begin
                            if (sci) begin
                                if (r_echars != '0) fail = 1'b1;
                                n_flags[FL_ENEG] = 1'b1;
                            end else begin
                                if (r_flags[FL_NEG] || r_mchars != '0) fail = 1'b1;
                                n_mchars        = r_mchars + CW'(1);
                                n_flags[FL_NEG] = 1'b1;
                            end
                        end
                        CH_PLUS: begin
                            if (!sci || r_echars != '0) fail = 1'b1;
                            n_flags[FL_EPOS] = 1'b1;
                        end
                        default: begin
                            if (is_digit) begin
                                if (sci) begin
                                    if (r_echars >= CW'(cdfp_pkg::MAX_FIELD_CHARS)) begin
                                        fail  = 1'b1;
                                        fcode = cdfp_pkg::ST_TOO_LONG;
                                    end
                                    n_echars = r_echars + CW'(1);
                                    if (!r_flags[FL_EDOT]) begin
                                        n_eacc = (eacc_w > 11'(cdfp_pkg::EXP_CAP))
                                               ? cdfp_pkg::EXP_W'(cdfp_pkg::EXP_CAP)
                                               : eacc_w[cdfp_pkg::EXP_W-1:0];
                                    end
                                end else begin
                                    if (r_mchars >= CW'(cdfp_pkg::MAX_FIELD_CHARS)) begin
                                        fail  = 1'b1;
                                        fcode = cdfp_pkg::ST_TOO_LONG;
                                    end
                                    n_mchars = r_mchars + CW'(1);
                                    n_macc   = (|macc_w[cdfp_pkg::ACC_W+3:cdfp_pkg::ACC_W])
                                             ? {cdfp_pkg::ACC_W{1'b1}}
                                             : macc_w[cdfp_pkg::ACC_W-1:0];
                                    if (r_flags[FL_DOT]) n_frac = r_frac + CW'(1);
                                end
                            end
                        end
                    endcase
                    open_field = (n_mchars != '0) || (n_echars != '0) || (n_flags != '0);
                    if (fail) begin
                        n_halted   = 1'b1;
                        n_p_value  = '0;
                        n_p_idx    = '0;
                        n_p_status = fcode;
                        n_p_last   = 1'b1;
                        n_state    = S_EMIT;
                    end else if (delim || (i_end_of_stream && open_field)) begin
                        n_eos   = i_end_of_stream;
                        n_state = S_END;
                    end else if (i_end_of_stream) begin
                        n_macc     = '0;
                        n_mchars   = '0;
                        n_frac     = '0;
                        n_eacc     = '0;
                        n_echars   = '0;
                        n_flags    = '0;
                        n_count    = '0;
                        n_p_value  = '0;
                        n_p_idx    = '0;
                        n_p_status = cdfp_pkg::ST_NO_VALUE;
                        n_p_last   = 1'b1;
                        n_state    = S_EMIT;
                    end
                end
            end
            S_END: begin
                n_p_value = '0;
                n_p_idx   = '0;
                n_p_last  = 1'b1;
                if (r_mchars == '0) begin
                    n_halted   = 1'b1;
                    n_p_status = cdfp_pkg::ST_EMPTY;
                    n_state    = S_EMIT;
                end else if (r_cfg_rgbg && r_count[0]) begin
                    // odd field in RGBG mode: dropped without a value; at end of stream a no-value marker follows
                    n_macc   = '0;
                    n_mchars = '0;
                    n_frac   = '0;
                    n_eacc   = '0;
                    n_echars = '0;
                    n_flags  = '0;
                    n_count  = r_count + NW'(1);
                    if (r_eos) begin
                        n_count    = '0;
                        n_p_status = cdfp_pkg::ST_NO_VALUE;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (r_flags[FL_SCI] && (r_flags[FL_ENEG] == r_flags[FL_EPOS])) begin
                    n_halted   = 1'b1;
                    n_p_status = cdfp_pkg::ST_MALFORMED;
                    n_state    = S_EMIT;
                end else if (cdfp_pkg::LIM_W'(idx) >= limit) begin
                    n_halted   = 1'b1;
                    n_p_status = cdfp_pkg::ST_TOO_MANY;
                    n_state    = S_EMIT;
                end else begin
                    n_req.start = 1'b1;
                    n_req.mant  = r_macc;
                    n_req.k     = k_val;
                    n_req.gain  = r_cfg_exp_en ? cdfp_pkg::GAIN_W'(cdfp_pkg::EXPO_GAIN)
                                               : cdfp_pkg::GAIN_W'(1);
                    n_req.div   = (r_cfg_exp_en && r_cfg_exp_time != '0)
                                ? r_cfg_exp_time : cdfp_pkg::DIV_W'(1);
                    n_neg       = r_flags[FL_NEG];
                    n_p_idx     = idx[cdfp_pkg::IDX_W-1:0];
                    n_p_status  = cdfp_pkg::ST_VALUE;
                    n_p_last    = r_eos;
                    n_macc      = '0;
                    n_mchars    = '0;
                    n_frac      = '0;
                    n_eacc      = '0;
                    n_echars    = '0;
                    n_flags     = '0;
                    n_count     = r_eos ? '0 : r_count + NW'(1);
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (scale_rsp.done) begin
                    n_p_value = r_neg ? neg_sat[VW-1:0] : sat[VW-1:0];
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_value   = r_p_value;
                    n_o_idx     = r_p_idx;
                    n_o_status  = r_p_status;
                    n_o_last    = r_p_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_macc         <= '0;
            r_mchars       <= '0;
            r_frac         <= '0;
            r_eacc         <= '0;
            r_echars       <= '0;
            r_flags        <= '0;
            r_count        <= '0;
            r_halted       <= 1'b0;
            r_cfg_limit    <= 22'd1555200;
            r_cfg_exp_en   <= 1'b0;
            r_cfg_exp_time <= 16'd1;
            r_cfg_rgbg     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_req.start    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_macc         <= n_macc;
            r_mchars       <= n_mchars;
            r_frac         <= n_frac;
            r_eacc         <= n_eacc;
            r_echars       <= n_echars;
            r_flags        <= n_flags;
            r_count        <= n_count;
            r_halted       <= n_halted;
            r_cfg_limit    <= n_cfg_limit;
            r_cfg_exp_en   <= n_cfg_exp_en;
            r_cfg_exp_time <= n_cfg_exp_time;
            r_cfg_rgbg     <= n_cfg_rgbg;
            r_out_valid    <= n_out_valid;
            r_req.start    <= n_req.start;
        end
        r_req.mant <= n_req.mant;
        r_req.k    <= n_req.k;
        r_req.gain <= n_req.gain;
        r_req.div  <= n_req.div;
        r_eos      <= n_eos;
        r_neg      <= n_neg;
        r_p_value  <= n_p_value;
        r_p_idx    <= n_p_idx;
        r_p_status <= n_p_status;
        r_p_last   <= n_p_last;
        r_o_value  <= n_o_value;
        r_o_idx    <= n_o_idx;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_value       = r_o_value;
    assign o_pixel_index = r_o_idx;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

endmodule
`default_nettype wire

// ===== hw/rtl/cdfp_checker.sv =====
`default_nettype none
module cdfp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic signed [cdfp_pkg::VAL_W-1:0] o_value,
    input wire logic [cdfp_pkg::IDX_W-1:0]     o_pixel_index,
    input wire logic [cdfp_pkg::ST_W-1:0]      o_status,
    input wire logic                           o_last
);
    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_pixel_index) && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // error and end markers carry last and a zero payload
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != cdfp_pkg::ST_VALUE |->
            o_last && o_value == '0 && o_pixel_index == '0)
        else $error("error word malformed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= cdfp_pkg::ST_NO_VALUE)
        else $error("status out of range");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

endmodule

bind csv_decimal_field_parser_top cdfp_checker u_cdfp_checker (.*);
`default_nettype wire
